// File: sv/jisr_pkg.sv
`timescale 1ns / 1ps

package jisr_pkg;

  localparam int NUM_JOINTS     = 12;
  localparam int JOINTS_PER_LEG = 3;
  localparam int KNEE_SLOT      = 2;

  localparam int POS_W     = 16;
  localparam int JIDX_W    = $clog2(NUM_JOINTS);
  localparam int REGION_W  = 2;
  localparam int ADDR_W    = REGION_W + JIDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int CNT_W     = $clog2(NUM_JOINTS + 2);

  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int ALPHA_W   = 17;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
  localparam logic [17:0]        SMOOTH_K   = 18'd196608;
  localparam logic signed [34:0] BLEND_HALF = 35'sd32768;

  localparam logic [REGION_W-1:0] REG_DEF    = 2'b00;
  localparam logic [REGION_W-1:0] REG_START  = 2'b01;
  localparam logic                REG_CMD_HI = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_DEF = 2'd0,
    OP_SEED     = 2'd1,
    OP_CMD      = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_TARGET   = 2'd0,
    STAT_STORED   = 2'd1,
    STAT_ACCEPT   = 2'd2,
    STAT_SIZE_ERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_RAMP_EN   = 2'd0,
    CFG_LINK_EN   = 2'd1,
    CFG_HOLD      = 2'd2,
    CFG_RAMP_TIME = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [POS_W-1:0]     data;
  } pose_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ramp_t;
    logic [31:0] ramp_time;
  } alpha_req_t;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] alpha;
  } alpha_rsp_t;

  function automatic logic [NUM_JOINTS-1:0] knee_mask_f();
    logic [NUM_JOINTS-1:0] m;
    m = '0;
    for (int i = 0; i < NUM_JOINTS; i++) begin
      m[i] = ((i % JOINTS_PER_LEG) == KNEE_SLOT) &&
             (i < (NUM_JOINTS / JOINTS_PER_LEG) * JOINTS_PER_LEG);
    end
    return m;
  endfunction

  localparam logic [NUM_JOINTS-1:0] KNEE_MASK = knee_mask_f();

endpackage

// File: sv/jisr_if.sv
`timescale 1ns / 1ps

interface jisr_in_if;
  import jisr_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [3:0]        joint_index;
  logic signed [15:0] position;
  logic              position_valid;
  logic              last_word;
  logic [15:0]       period_us;

  modport source (output valid, operation, joint_index, position, position_valid,
                  last_word, period_us, input ready);
  modport sink (input valid, operation, joint_index, position, position_valid,
                last_word, period_us, output ready);
endinterface

interface jisr_out_if;
  import jisr_pkg::*;
  logic               valid;
  logic               ready;
  logic [3:0]         out_joint;
  logic signed [15:0] target_position;
  logic [1:0]         status;
  logic               out_last;

  modport source (output valid, out_joint, target_position, status, out_last,
                  input ready);
  modport sink (input valid, out_joint, target_position, status, out_last,
                output ready);
endinterface

// File: sv/jisr_pose_mem.sv
`timescale 1ns / 1ps

module jisr_pose_mem (
  input  logic                         clk,
  input  jisr_pkg::pose_wr_t           wr,
  input  logic [jisr_pkg::ADDR_W-1:0]  rd_addr,
  output logic [jisr_pkg::POS_W-1:0]   rd_data
);
  import jisr_pkg::*;

  logic [POS_W-1:0] mem [MEM_DEPTH];
  logic [POS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/jisr_alpha.sv
`timescale 1ns / 1ps

module jisr_alpha (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jisr_pkg::alpha_req_t req,
  output jisr_pkg::alpha_rsp_t rsp
);
  import jisr_pkg::*;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_DIV  = 5'b00010,
    A_SQ   = 5'b00100,
    A_MUL  = 5'b01000,
    A_DONE = 5'b10000
  } astate_t;

  astate_t              state_r, state_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          div_r, div_nxt;
  logic [15:0]          q_r, q_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          sq_r, sq_nxt;
  logic [17:0]          wgt_r, wgt_nxt;
  logic [ALPHA_W-1:0]   alpha_r, alpha_nxt;
  logic [32:0]          rem2;
  logic [32:0]          rem_sub;
  logic                 ge;
  logic [49:0]          prod;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    wgt_nxt   = wgt_r;
    alpha_nxt = alpha_r;
    rem2      = {rem_r, 1'b0};
    rem_sub   = rem2 - {1'b0, div_r};
    ge        = (rem2 >= {1'b0, div_r});
    prod      = {18'd0, sq_r} * {32'd0, wgt_r};
    unique case (state_r)
      A_IDLE: begin
        if (req.start) begin
          if (req.ramp_t >= req.ramp_time) begin
            alpha_nxt = ALPHA_ONE;
            state_nxt = A_DONE;
          end else begin
            rem_nxt   = req.ramp_t;
            div_nxt   = req.ramp_time;
            q_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = A_DIV;
          end
        end
      end
      A_DIV: begin
        rem_nxt = ge ? rem_sub[31:0] : rem2[31:0];
        q_nxt   = {q_r[14:0], ge};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = A_SQ;
        end
      end
      A_SQ: begin
        sq_nxt    = {16'd0, q_r} * {16'd0, q_r};
        wgt_nxt   = SMOOTH_K - {1'b0, q_r, 1'b0};
        state_nxt = A_MUL;
      end
      A_MUL: begin
        alpha_nxt = prod[48:32];
        state_nxt = A_DONE;
      end
      A_DONE: begin
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    q_r     <= q_nxt;
    cnt_r   <= cnt_nxt;
    sq_r    <= sq_nxt;
    wgt_r   <= wgt_nxt;
    alpha_r <= alpha_nxt;
  end

  assign rsp.done  = (state_r == A_DONE);
  assign rsp.alpha = alpha_r;

endmodule

// File: sv/joint_idle_smoothstep_ramp.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake     Payload
// in_ch     input      valid/ready   operation, joint_index, position,
//                                    position_valid, last_word, period_us
// out_ch    output     valid/ready   out_joint, target_position, status, out_last
// cfg_*     input      cfg_we        cfg_index, cfg_data (no read-back)
//
// One transaction at a time. Command words and default loads are handled in
// the issue state. Seeds and ticks make four pose memory reads, then the
// update. A ramp-phase tick at joint zero also waits for the alpha unit
// (16-step divider, square, weight multiply) before the blend is computed.
// Reset clears all control state; pose entries read as zero until written.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits for it before its own result is loaded.

module joint_idle_smoothstep_ramp (
  input  logic       clk,
  input  logic       rst_n,
  jisr_in_if.sink    in_ch,
  jisr_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import jisr_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_ISSUE    = 11'b00000000010,
    S_RD_CMD   = 11'b00000000100,
    S_RD_HIP   = 11'b00000001000,
    S_RD_START = 11'b00000010000,
    S_GATHER   = 11'b00000100000,
    S_ALPHA    = 11'b00001000000,
    S_DECIDE   = 11'b00010000000,
    S_SEED_WR  = 11'b00100000000,
    S_BLEND    = 11'b01000000000,
    S_RESULT   = 11'b10000000000
  } state_t;

  state_t                  state_r, state_nxt;

  logic                    ramp_en_r, ramp_en_nxt;
  logic                    link_en_r, link_en_nxt;
  logic [31:0]             hold_r, hold_nxt;
  logic [31:0]             ramp_time_r, ramp_time_nxt;

  logic [CNT_W-1:0]        pend_cnt_r, pend_cnt_nxt;
  logic                    ext_act_r, ext_act_nxt;
  logic                    ramp_started_r, ramp_started_nxt;
  logic [31:0]             elapsed_r, elapsed_nxt;
  logic [ALPHA_W-1:0]      alpha_now_r, alpha_now_nxt;
  logic                    cmd_bank_r, cmd_bank_nxt;
  logic [NUM_JOINTS-1:0]   def_vld_r, def_vld_nxt;
  logic [NUM_JOINTS-1:0]   start_vld_r, start_vld_nxt;
  logic [NUM_JOINTS-1:0]   cmd_vld_r, cmd_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;

  op_t                     op_r, op_nxt;
  logic [3:0]              j_r, j_nxt;
  logic signed [15:0]      pos_r, pos_nxt;
  logic                    pvld_r, pvld_nxt;
  logic                    lastw_r, lastw_nxt;
  logic [15:0]             period_r, period_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic signed [15:0]      def_v_r, def_v_nxt;
  logic signed [15:0]      cmd_v_r, cmd_v_nxt;
  logic signed [15:0]      hip_v_r, hip_v_nxt;
  logic signed [15:0]      start_v_r, start_v_nxt;
  logic signed [15:0]      blend_start_r, blend_start_nxt;
  logic signed [34:0]      prod_r, prod_nxt;
  logic [3:0]              res_joint_r, res_joint_nxt;
  logic signed [15:0]      res_pos_r, res_pos_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic                    res_last_r, res_last_nxt;
  logic [3:0]              out_joint_r, out_joint_nxt;
  logic signed [15:0]      out_pos_r, out_pos_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;

  pose_wr_t                mem_wr;
  logic [ADDR_W-1:0]       mem_rd_addr;
  logic [POS_W-1:0]        mem_rd_data;
  alpha_req_t              alpha_req;
  alpha_rsp_t              alpha_rsp;

  logic [JIDX_W-1:0]       jx;
  logic [JIDX_W-1:0]       hipx;
  logic                    j_in_range;
  logic                    j_zero;
  logic                    j_last;
  logic                    ramp_path;
  logic [1:0]              cmd_region;
  logic [1:0]              pend_region;
  logic signed [15:0]      rd_val;
  logic [CNT_W-1:0]        cnt_inc;
  logic [32:0]             esum;
  logic signed [15:0]      seed_v;
  logic signed [15:0]      meas;
  logic signed [15:0]      st_pose;
  logic signed [16:0]      diff;
  logic signed [17:0]      alpha_s;
  logic signed [34:0]      prod_w;
  logic signed [34:0]      rnd_w;
  logic signed [16:0]      knee_d;
  logic signed [15:0]      knee_t;

  jisr_pose_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  jisr_alpha u_alpha (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alpha_req),
    .rsp   (alpha_rsp)
  );

  assign jx          = JIDX_W'(j_r);
  assign hipx        = (jx == '0) ? '0 : jx - JIDX_W'(1);
  assign j_in_range  = (32'(j_r) < 32'(NUM_JOINTS));
  assign j_zero      = (jx == '0);
  assign j_last      = (jx == JIDX_W'(NUM_JOINTS - 1));
  assign ramp_path   = !ext_act_r && ramp_en_r && (ramp_time_r != '0);
  assign cmd_region  = {REG_CMD_HI, cmd_bank_r};
  assign pend_region = {REG_CMD_HI, ~cmd_bank_r};
  assign rd_val      = rd_vld_r ? signed'(mem_rd_data) : '0;
  assign cnt_inc     = (pend_cnt_r <= CNT_W'(NUM_JOINTS)) ? pend_cnt_r + CNT_W'(1)
                                                          : pend_cnt_r;
  assign esum        = {1'b0, elapsed_r} + {17'd0, period_r};
  assign seed_v      = pvld_r ? pos_r : def_v_r;
  assign meas        = pvld_r ? pos_r : cmd_v_r;
  assign st_pose     = ramp_started_r ? start_v_r : meas;
  assign diff        = {def_v_r[15], def_v_r} - {st_pose[15], st_pose};
  assign alpha_s     = {1'b0, alpha_now_r};
  assign prod_w      = diff * alpha_s;
  assign rnd_w       = (prod_r + BLEND_HALF) >>> 16;
  assign knee_d      = {cmd_v_r[15], cmd_v_r} - {hip_v_r[15], hip_v_r};
  assign knee_t      = (knee_d[16] != knee_d[15]) ? (knee_d[16] ? 16'sh8000 : 16'sh7FFF)
                                                  : knee_d[15:0];

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_vld_r;
  assign out_ch.out_joint       = out_joint_r;
  assign out_ch.target_position = out_pos_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.out_last        = out_last_r;

  always_comb begin
    state_nxt        = state_r;
    ramp_en_nxt      = ramp_en_r;
    link_en_nxt      = link_en_r;
    hold_nxt         = hold_r;
    ramp_time_nxt    = ramp_time_r;
    pend_cnt_nxt     = pend_cnt_r;
    ext_act_nxt      = ext_act_r;
    ramp_started_nxt = ramp_started_r;
    elapsed_nxt      = elapsed_r;
    alpha_now_nxt    = alpha_now_r;
    cmd_bank_nxt     = cmd_bank_r;
    def_vld_nxt      = def_vld_r;
    start_vld_nxt    = start_vld_r;
    cmd_vld_nxt      = cmd_vld_r;
    out_vld_nxt      = out_vld_r;
    op_nxt           = op_r;
    j_nxt            = j_r;
    pos_nxt          = pos_r;
    pvld_nxt         = pvld_r;
    lastw_nxt        = lastw_r;
    period_nxt       = period_r;
    rd_vld_nxt       = rd_vld_r;
    def_v_nxt        = def_v_r;
    cmd_v_nxt        = cmd_v_r;
    hip_v_nxt        = hip_v_r;
    start_v_nxt      = start_v_r;
    blend_start_nxt  = blend_start_r;
    prod_nxt         = prod_r;
    res_joint_nxt    = res_joint_r;
    res_pos_nxt      = res_pos_r;
    res_status_nxt   = res_status_r;
    res_last_nxt     = res_last_r;
    out_joint_nxt    = out_joint_r;
    out_pos_nxt      = out_pos_r;
    out_status_nxt   = out_status_r;
    out_last_nxt     = out_last_r;

    mem_wr              = '0;
    mem_rd_addr         = {REG_DEF, jx};
    alpha_req.start     = 1'b0;
    alpha_req.ramp_t    = elapsed_r - hold_r;
    alpha_req.ramp_time = ramp_time_r;

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RAMP_EN:   ramp_en_nxt   = cfg_data[0];
        CFG_LINK_EN:   link_en_nxt   = cfg_data[0];
        CFG_HOLD:      hold_nxt      = cfg_data;
        CFG_RAMP_TIME: ramp_time_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = op_t'(in_ch.operation);
          j_nxt      = in_ch.joint_index;
          pos_nxt    = in_ch.position;
          pvld_nxt   = in_ch.position_valid;
          lastw_nxt  = in_ch.last_word;
          period_nxt = in_ch.period_us;
          state_nxt  = S_ISSUE;
        end
      end

      S_ISSUE: begin
        mem_rd_addr = {REG_DEF, jx};
        rd_vld_nxt  = def_vld_r[jx];
        if (op_r == OP_CMD) begin
          res_joint_nxt  = '0;
          res_pos_nxt    = pos_r;
          res_status_nxt = STAT_STORED;
          res_last_nxt   = 1'b0;
          if (pend_cnt_r < CNT_W'(NUM_JOINTS)) begin
            mem_wr.en     = 1'b1;
            mem_wr.addr   = {pend_region, JIDX_W'(pend_cnt_r)};
            mem_wr.data   = pos_r;
            res_joint_nxt = 4'(pend_cnt_r);
          end
          if (!lastw_r) begin
            pend_cnt_nxt = cnt_inc;
          end else if (cnt_inc == CNT_W'(NUM_JOINTS)) begin
            cmd_bank_nxt   = ~cmd_bank_r;
            cmd_vld_nxt    = '1;
            ext_act_nxt    = 1'b1;
            pend_cnt_nxt   = '0;
            res_joint_nxt  = '0;
            res_pos_nxt    = '0;
            res_status_nxt = STAT_ACCEPT;
          end else begin
            pend_cnt_nxt   = '0;
            res_joint_nxt  = '0;
            res_pos_nxt    = '0;
            res_status_nxt = STAT_SIZE_ERR;
          end
          state_nxt = S_RESULT;
        end else if (!j_in_range) begin
          state_nxt = S_IDLE;
        end else if (op_r == OP_LOAD_DEF) begin
          mem_wr.en        = 1'b1;
          mem_wr.addr      = {REG_DEF, jx};
          mem_wr.data      = pos_r;
          def_vld_nxt[jx]  = 1'b1;
          res_joint_nxt    = j_r;
          res_pos_nxt      = pos_r;
          res_status_nxt   = STAT_STORED;
          res_last_nxt     = 1'b0;
          state_nxt        = S_RESULT;
        end else begin
          if ((op_r == OP_TICK) && ramp_path && j_zero) begin
            elapsed_nxt = esum[32] ? '1 : esum[31:0];
          end
          state_nxt = S_RD_CMD;
        end
      end

      S_RD_CMD: begin
        def_v_nxt   = rd_val;
        mem_rd_addr = {cmd_region, jx};
        rd_vld_nxt  = cmd_vld_r[jx];
        state_nxt   = S_RD_HIP;
      end

      S_RD_HIP: begin
        cmd_v_nxt   = rd_val;
        mem_rd_addr = {cmd_region, hipx};
        rd_vld_nxt  = cmd_vld_r[hipx];
        state_nxt   = S_RD_START;
      end

      S_RD_START: begin
        hip_v_nxt   = rd_val;
        mem_rd_addr = {REG_START, jx};
        rd_vld_nxt  = start_vld_r[jx];
        state_nxt   = S_GATHER;
      end

      S_GATHER: begin
        start_v_nxt = rd_val;
        if ((op_r == OP_TICK) && ramp_path && j_zero && (elapsed_r > hold_r)) begin
          alpha_req.start = 1'b1;
          state_nxt       = S_ALPHA;
        end else begin
          state_nxt = S_DECIDE;
        end
      end

      S_ALPHA: begin
        if (alpha_rsp.done) begin
          alpha_now_nxt = alpha_rsp.alpha;
          state_nxt     = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_joint_nxt  = j_r;
        res_status_nxt = STAT_TARGET;
        res_last_nxt   = j_last;
        state_nxt      = S_RESULT;
        if (op_r == OP_SEED) begin
          mem_wr.en       = 1'b1;
          mem_wr.addr     = {cmd_region, jx};
          mem_wr.data     = seed_v;
          cmd_vld_nxt[jx] = 1'b1;
          res_pos_nxt     = seed_v;
          if (j_zero) begin
            ext_act_nxt      = 1'b0;
            ramp_started_nxt = 1'b0;
            elapsed_nxt      = '0;
            pend_cnt_nxt     = '0;
          end
          state_nxt = S_SEED_WR;
        end else if (ext_act_r) begin
          res_pos_nxt = (link_en_r && KNEE_MASK[jx]) ? knee_t : cmd_v_r;
        end else if (ramp_path) begin
          if (elapsed_r <= hold_r) begin
            mem_wr.en         = 1'b1;
            mem_wr.addr       = {REG_START, jx};
            mem_wr.data       = meas;
            start_vld_nxt[jx] = 1'b1;
            ramp_started_nxt  = 1'b0;
            res_pos_nxt       = meas;
          end else begin
            if (!ramp_started_r) begin
              mem_wr.en         = 1'b1;
              mem_wr.addr       = {REG_START, jx};
              mem_wr.data       = meas;
              start_vld_nxt[jx] = 1'b1;
            end
            if (j_last) begin
              ramp_started_nxt = 1'b1;
            end
            blend_start_nxt = st_pose;
            prod_nxt        = prod_w;
            state_nxt       = S_BLEND;
          end
        end else begin
          res_pos_nxt = cmd_v_r;
        end
      end

      S_SEED_WR: begin
        mem_wr.en         = 1'b1;
        mem_wr.addr       = {REG_START, jx};
        mem_wr.data       = res_pos_r;
        start_vld_nxt[jx] = 1'b1;
        state_nxt         = S_RESULT;
      end

      S_BLEND: begin
        res_pos_nxt = blend_start_r + signed'(rnd_w[15:0]);
        state_nxt   = S_RESULT;
      end

      S_RESULT: begin
        if (!out_vld_r || out_ch.ready) begin
          out_joint_nxt  = res_joint_r;
          out_pos_nxt    = res_pos_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = res_last_r;
          out_vld_nxt    = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      ramp_en_r      <= 1'b0;
      link_en_r      <= 1'b0;
      hold_r         <= '0;
      ramp_time_r    <= '0;
      pend_cnt_r     <= '0;
      ext_act_r      <= 1'b0;
      ramp_started_r <= 1'b0;
      elapsed_r      <= '0;
      alpha_now_r    <= '0;
      cmd_bank_r     <= 1'b0;
      def_vld_r      <= '0;
      start_vld_r    <= '0;
      cmd_vld_r      <= '0;
      out_vld_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      ramp_en_r      <= ramp_en_nxt;
      link_en_r      <= link_en_nxt;
      hold_r         <= hold_nxt;
      ramp_time_r    <= ramp_time_nxt;
      pend_cnt_r     <= pend_cnt_nxt;
      ext_act_r      <= ext_act_nxt;
      ramp_started_r <= ramp_started_nxt;
      elapsed_r      <= elapsed_nxt;
      alpha_now_r    <= alpha_now_nxt;
      cmd_bank_r     <= cmd_bank_nxt;
      def_vld_r      <= def_vld_nxt;
      start_vld_r    <= start_vld_nxt;
      cmd_vld_r      <= cmd_vld_nxt;
      out_vld_r      <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    j_r           <= j_nxt;
    pos_r         <= pos_nxt;
    pvld_r        <= pvld_nxt;
    lastw_r       <= lastw_nxt;
    period_r      <= period_nxt;
    rd_vld_r      <= rd_vld_nxt;
    def_v_r       <= def_v_nxt;
    cmd_v_r       <= cmd_v_nxt;
    hip_v_r       <= hip_v_nxt;
    start_v_r     <= start_v_nxt;
    blend_start_r <= blend_start_nxt;
    prod_r        <= prod_nxt;
    res_joint_r   <= res_joint_nxt;
    res_pos_r     <= res_pos_nxt;
    res_status_r  <= res_status_nxt;
    res_last_r    <= res_last_nxt;
    out_joint_r   <= out_joint_nxt;
    out_pos_r     <= out_pos_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule
